@@ src/isgu_pkg.sv @@
// ----------------------------------------------------------------------------
// isgu_pkg
// Shared constants for the index set grouping unit: default sizes,
// beat action codes and result status codes.
// ----------------------------------------------------------------------------
package isgu_pkg;

	// default table sizes
	localparam int DEF_MAX_BLOCKS = 64;
	localparam int DEF_MAX_COEFF  = 64;

	// orbital numbers wrap after this many orbitals
	localparam int MAX_ORBITALS = 65536;

	// field widths
	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 12;
	localparam int ORB_W    = 16;
	localparam int BLKNUM_W = 6;
	localparam int STATUS_W = 2;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;

	// beat actions
	localparam action_t ACT_INDEX = 2'd0;
	localparam action_t ACT_FINAL = 2'd1;
	localparam action_t ACT_EMPTY = 2'd2;
	localparam action_t ACT_CLEAR = 2'd3;

	// result status codes
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_TOO_MANY = 2'd2;

endpackage

@@ src/isgu_ram.sv @@
// ----------------------------------------------------------------------------
// isgu_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module isgu_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/index_set_grouping_unit.sv @@
// ----------------------------------------------------------------------------
// index_set_grouping_unit
// Groups orbitals into blocks by the set of basis indices they use.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is accepted on a rising edge with start high and busy low. An
//   orbital is a run of index beats closed by a final-index beat, or a single
//   empty-orbital beat; a clear beat empties the block table and restarts the
//   orbital numbering. Index and clear beats leave busy low.
//   A closing beat raises busy while the sequencer searches the blocks; the
//   result is shown for one cycle with done high, in the cycle busy drops.
//   The sequencer tries the blocks in order and skips each block whose count
//   differs from the orbital's index count n; for a block whose count is n
//   it looks up each index in turn in the block's representative list, and
//   the block matches when every index is found, or is left at the first
//   index missed. If no block matches, a new block is opened and the indices
//   are copied into it, or the status is full when the table is full. An
//   orbital with too many indices is reported without a search. The next
//   beat is taken once busy has dropped. The search uses the single read port
//   of the representative list memory and the one index comparator.
//   The receiver cannot stall: done is a strobe and must be taken at once.
//   Reset clears the block table, the buffered run and the orbital counter;
//   the index memories need no clearing, only written entries are read.
// ----------------------------------------------------------------------------
module index_set_grouping_unit #(
	parameter int MAX_BLOCKS = isgu_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_COEFF  = isgu_pkg::DEF_MAX_COEFF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [isgu_pkg::ACTION_W-1:0] action,
	input  logic [isgu_pkg::INDEX_W-1:0]  basis_index,
	output logic                          done,
	output logic [isgu_pkg::ORB_W-1:0]    orbital_number,
	output logic [isgu_pkg::BLKNUM_W-1:0] block_number,
	output logic                          new_block,
	output logic [isgu_pkg::STATUS_W-1:0] status
);

	localparam int CNT_W  = $clog2(MAX_COEFF + 1);
	localparam int CIDX_W = (MAX_COEFF > 1) ? $clog2(MAX_COEFF) : 1;
	localparam int BCNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int BIDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int REP_D  = MAX_BLOCKS * MAX_COEFF;
	localparam int REP_W  = (REP_D > 1) ? $clog2(REP_D) : 1;
	localparam int IDX_W  = isgu_pkg::INDEX_W;
	localparam int ORB_W  = isgu_pkg::ORB_W;

	localparam logic [CNT_W-1:0]  COEFF_LIM = CNT_W'(MAX_COEFF);
	localparam logic [BCNT_W-1:0] BLOCK_LIM = BCNT_W'(MAX_BLOCKS);
	localparam logic [ORB_W-1:0]  ORB_LAST  = ORB_W'(isgu_pkg::MAX_ORBITALS - 1);
	localparam logic [REP_W:0]    BASE_STEP = (REP_W + 1)'(MAX_COEFF);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_BLK    = 4'd2;
	localparam logic [3:0] S_BCNT   = 4'd3;
	localparam logic [3:0] S_ISTART = 4'd4;
	localparam logic [3:0] S_JISSUE = 4'd5;
	localparam logic [3:0] S_JCMP   = 4'd6;
	localparam logic [3:0] S_CISSUE = 4'd7;
	localparam logic [3:0] S_CWRITE = 4'd8;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  cur_cnt_q;
	logic              cur_ovf_q;
	logic [BCNT_W-1:0] blk_cnt_q;
	logic [ORB_W-1:0]  orb_q;
	logic [BCNT_W-1:0] b_q;
	logic [REP_W:0]    base_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;

	logic                          done_q;
	logic [ORB_W-1:0]              orbital_number_q;
	logic [isgu_pkg::BLKNUM_W-1:0] block_number_q;
	logic                          new_block_q;
	logic [isgu_pkg::STATUS_W-1:0] status_q;

	logic                accept;
	logic                push;
	logic                orb_close;
	logic                cur_we;
	logic [IDX_W-1:0]    cur_rdata;
	logic                cnt_we;
	logic [CNT_W-1:0]    cnt_rdata;
	logic                rep_we;
	logic [IDX_W-1:0]    rep_rdata;
	logic [CNT_W-1:0]    rep_off;
	logic [REP_W:0]      rep_addr;
	logic [BIDX_W+5:0]   blk_ext;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// index beat into the buffer when there is room
	assign push   = accept && ((action == isgu_pkg::ACT_INDEX) ||
			(action == isgu_pkg::ACT_FINAL));
	assign cur_we = push && (cur_cnt_q < COEFF_LIM);

	// orbital closes: overflow, full table, match found or copy finished
	assign orb_close = ((state_q == S_CHECK) && cur_ovf_q) ||
			((state_q == S_BLK) && (b_q == blk_cnt_q) &&
			 (blk_cnt_q >= BLOCK_LIM)) ||
			((state_q == S_ISTART) && (i_q == cur_cnt_q)) ||
			((state_q == S_CISSUE) && (i_q == cur_cnt_q));

	// a new block's count is written as the copy starts
	assign cnt_we = (state_q == S_BLK) && (b_q == blk_cnt_q) &&
			(blk_cnt_q < BLOCK_LIM);

	// shared representative list address: compare offset or copy offset
	assign rep_we   = (state_q == S_CWRITE);
	assign rep_off  = rep_we ? i_q : j_q;
	assign rep_addr = base_q + (REP_W + 1)'(rep_off);

	// block position as the 6-bit result field
	assign blk_ext = {6'b0, b_q[BIDX_W-1:0]};

	// buffered indices of the current orbital
	isgu_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_COEFF)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_cnt_q[CIDX_W-1:0]),
		.wdata (basis_index),
		.raddr (i_q[CIDX_W-1:0]),
		.rdata (cur_rdata)
	);

	// representative index count of each block
	isgu_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_BLOCKS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (b_q[BIDX_W-1:0]),
		.wdata (cur_cnt_q),
		.raddr (b_q[BIDX_W-1:0]),
		.rdata (cnt_rdata)
	);

	// representative index lists, one row of MAX_COEFF entries per block
	isgu_ram #(
		.WIDTH (IDX_W),
		.DEPTH (REP_D)
	) u_rep_ram (
		.clk   (clk),
		.we    (rep_we),
		.waddr (rep_addr[REP_W-1:0]),
		.wdata (cur_rdata),
		.raddr (rep_addr[REP_W-1:0]),
		.rdata (rep_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_cnt_q <= '0;
			cur_ovf_q <= 1'b0;
			blk_cnt_q <= '0;
			orb_q     <= '0;
			b_q       <= '0;
			base_q    <= '0;
			i_q       <= '0;
			j_q       <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= orb_close;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							isgu_pkg::ACT_INDEX, isgu_pkg::ACT_FINAL: begin
								if (cur_cnt_q < COEFF_LIM) begin
									cur_cnt_q <= cur_cnt_q + CNT_W'(1);
								end else begin
									cur_ovf_q <= 1'b1;
								end
								if (action == isgu_pkg::ACT_FINAL) begin
									state_q <= S_CHECK;
								end
							end
							isgu_pkg::ACT_EMPTY: begin
								cur_cnt_q <= '0;
								cur_ovf_q <= 1'b0;
								state_q   <= S_CHECK;
							end
							default: begin
								cur_cnt_q <= '0;
								cur_ovf_q <= 1'b0;
								blk_cnt_q <= '0;
								orb_q     <= '0;
							end
						endcase
					end
				end
				S_CHECK: begin
					b_q    <= '0;
					base_q <= '0;
					if (cur_ovf_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BLK;
					end
				end
				S_BLK: begin
					i_q <= '0;
					if (b_q == blk_cnt_q) begin
						if (blk_cnt_q < BLOCK_LIM) begin
							state_q <= S_CISSUE;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_BCNT;
					end
				end
				S_BCNT: begin
					if (cnt_rdata == cur_cnt_q) begin
						state_q <= S_ISTART;
					end else begin
						b_q     <= b_q + BCNT_W'(1);
						base_q  <= base_q + BASE_STEP;
						state_q <= S_BLK;
					end
				end
				S_ISTART: begin
					j_q <= '0;
					if (i_q == cur_cnt_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_JISSUE;
					end
				end
				S_JISSUE: begin
					if (j_q == cur_cnt_q) begin
						b_q     <= b_q + BCNT_W'(1);
						base_q  <= base_q + BASE_STEP;
						state_q <= S_BLK;
					end else begin
						state_q <= S_JCMP;
					end
				end
				S_JCMP: begin
					if (rep_rdata == cur_rdata) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_ISTART;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_JISSUE;
					end
				end
				S_CISSUE: begin
					if (i_q == cur_cnt_q) begin
						blk_cnt_q <= blk_cnt_q + BCNT_W'(1);
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_CWRITE;
					end
				end
				S_CWRITE: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_CISSUE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// orbital closes: advance numbering, empty buffer
			if (orb_close) begin
				cur_cnt_q <= '0;
				cur_ovf_q <= 1'b0;
				if (orb_q == ORB_LAST) begin
					orb_q <= '0;
				end else begin
					orb_q <= orb_q + ORB_W'(1);
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		orbital_number_q <= orb_q;
		if ((state_q == S_CHECK) && cur_ovf_q) begin
			block_number_q <= '0;
			new_block_q    <= 1'b0;
			status_q       <= isgu_pkg::ST_TOO_MANY;
		end else if (state_q == S_BLK) begin
			block_number_q <= '0;
			new_block_q    <= 1'b0;
			status_q       <= isgu_pkg::ST_FULL;
		end else if (state_q == S_CISSUE) begin
			block_number_q <= blk_ext[5:0];
			new_block_q    <= 1'b1;
			status_q       <= isgu_pkg::ST_OK;
		end else begin
			block_number_q <= blk_ext[5:0];
			new_block_q    <= 1'b0;
			status_q       <= isgu_pkg::ST_OK;
		end
	end

	assign done           = done_q;
	assign orbital_number = orbital_number_q;
	assign block_number   = block_number_q;
	assign new_block      = new_block_q;
	assign status         = status_q;

endmodule

@@ src/isgu_checker.sv @@
// ----------------------------------------------------------------------------
// isgu_checker
// Port-level checks for the index set grouping unit, bound to the top level.
// ----------------------------------------------------------------------------
module isgu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [isgu_pkg::ACTION_W-1:0] action,
	input logic [isgu_pkg::INDEX_W-1:0]  basis_index,
	input logic                          done,
	input logic [isgu_pkg::ORB_W-1:0]    orbital_number,
	input logic [isgu_pkg::BLKNUM_W-1:0] block_number,
	input logic                          new_block,
	input logic [isgu_pkg::STATUS_W-1:0] status
);

	// index and clear beats never cause a result
	property p_no_result_open;
		@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((action == isgu_pkg::ACT_INDEX) ||
			(action == isgu_pkg::ACT_CLEAR))) |=> !done;
	endproperty
	a_no_result_open: assert property (p_no_result_open)
		else $error("result after an index or clear beat");

	// a closing beat starts a search
	property p_close_busy;
		@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((action == isgu_pkg::ACT_FINAL) ||
			(action == isgu_pkg::ACT_EMPTY))) |=> busy;
	endproperty
	a_close_busy: assert property (p_close_busy)
		else $error("closing beat did not start a search");

	// the result comes as the unit frees up, one beat at a time
	property p_done_idle;
		@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy));
	endproperty
	a_done_idle: assert property (p_done_idle)
		else $error("result strobe outside the end of a search");

	// a new block only with ok status, failures report block zero
	property p_result_fields;
		@(posedge clk) disable iff (!arst_n)
		done |-> ((!new_block || (status == isgu_pkg::ST_OK)) &&
			((status == isgu_pkg::ST_OK) || (block_number == '0)));
	endproperty
	a_result_fields: assert property (p_result_fields)
		else $error("inconsistent result fields");

endmodule

bind index_set_grouping_unit isgu_checker u_isgu_checker (.*);
